@@ rtl/core/sorted_table_nearest_search_macros.svh @@
// Assertion helpers; clocked on clk, disabled while arst_n is low.
`ifndef SORTED_TABLE_NEAREST_SEARCH_MACROS_SVH
`define SORTED_TABLE_NEAREST_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define STNS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define STNS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STNS_ASSERT_NOW(lbl, ante, cons, msg)
`define STNS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/stns_pkg.sv @@
package stns_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 8;
	localparam int STAT_W   = 2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_INS_WALK = 5'b00010,
		ST_INS_PUT  = 5'b00100,
		ST_QRY_WALK = 5'b01000,
		ST_FINISH   = 5'b10000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic ins_step;
		logic ins_put;
		logic qry_step;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic ins_stop;
		logic idx_zero;
		logic qry_last;
	} sts_t;

endpackage

@@ rtl/core/sorted_table_nearest_search.sv @@
// Channel   Signals                                    Moves
// request   req_valid, req_ready, kind, item_value     insert or query
// result    res_valid, res_ready, nearest_value,       one result per request
//           exact_match, status
//
// A request holds the controller from the accept cycle until the finish step;
// res_valid rises on the edge that ends that step. An insert into a full table or a query
// of an empty one goes straight to the finish step; an insert into an empty table passes
// through the put step first. Other requests walk the table RAM, one entry per cycle
// through its registered read port.
// Reset (arst_n low) empties the table; no clearing pass, entries are written before read.
// A result waiting on res_ready stalls only the finish step; the next request is taken
// as soon as the controller is idle again.
module sorted_table_nearest_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic                               kind,
	input  logic [stns_pkg::VAL_W-1:0]         item_value,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [stns_pkg::VAL_W-1:0]         nearest_value,
	output logic                               exact_match,
	output logic [stns_pkg::STAT_W-1:0]        status
);
	import stns_pkg::*;

	// command and status between the state machine and the table datapath
	cmd_t cmd;
	sts_t sts;

	// Controller: sequences the insert shift walk (from the tail up to the slot)
	// and the query scan (from the head down), and owns the result valid flag.
	stns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.kind     (kind),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath: entry count, table RAM, nearest-value tracker and result register.
	stns_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.item_value   (item_value),
		.nearest_value(nearest_value),
		.exact_match  (exact_match),
		.status       (status)
	);

endmodule

@@ rtl/core/stns_ram.sv @@
module stns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/stns_dp.sv @@
module stns_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stns_pkg::cmd_t               cmd,
	output stns_pkg::sts_t               sts,
	input  logic                         kind,
	input  logic [stns_pkg::VAL_W-1:0]   item_value,
	output logic [stns_pkg::VAL_W-1:0]   nearest_value,
	output logic                         exact_match,
	output logic [stns_pkg::STAT_W-1:0]  status
);
	import stns_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic              kind_q;
	logic [VAL_W-1:0]  val_q;
	logic [STAT_W-1:0] stat_q;
	logic [VAL_W-1:0]  best_q;
	logic [VAL_W-1:0]  best_d_q;
	logic [VAL_W-1:0]  nearest_q;
	logic              exact_q;
	logic [STAT_W-1:0] res_stat_q;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [VAL_W-1:0]  wdata;
	logic [IDX_W-1:0]  raddr;
	logic [VAL_W-1:0]  rdata;
	logic [VAL_W-1:0]  diff;
	logic [CNT_W-1:0]  cnt_m1;
	logic [IDX_W-1:0]  idx_last;
	logic              ins_stop;
	logic              hit;

	assign cnt_m1   = count_q - CNT_W'(1);
	assign idx_last = cnt_m1[IDX_W-1:0];
	assign ins_stop = (rdata >= val_q);
	assign diff     = (rdata >= val_q) ? (rdata - val_q) : (val_q - rdata);
	assign hit      = (kind_q == KIND_QUERY) && (stat_q == STAT_OK);

	assign sts.full     = (count_q == CNT_W'(CAPACITY));
	assign sts.empty    = (count_q == '0);
	assign sts.ins_stop = ins_stop;
	assign sts.idx_zero = (idx_q == '0);
	assign sts.qry_last = (idx_q == idx_last);

	// one write port, one registered read port
	always_comb begin
		we    = 1'b0;
		waddr = idx_q + IDX_W'(1);
		wdata = val_q;
		raddr = idx_q;
		if (cmd.capture) begin
			raddr = (kind == KIND_QUERY) ? '0 : idx_last;
		end
		if (cmd.ins_step) begin
			// move the entry down one slot, or drop the new value in behind it
			we    = 1'b1;
			wdata = ins_stop ? val_q : rdata;
			raddr = idx_q - IDX_W'(1);
		end
		if (cmd.ins_put) begin
			we    = 1'b1;
			waddr = '0;
			wdata = val_q;
		end
		if (cmd.qry_step) begin
			raddr = idx_q + IDX_W'(1);
		end
	end

	stns_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.finish && kind_q == KIND_INSERT && stat_q == STAT_OK) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			val_q  <= item_value;
			idx_q  <= (kind == KIND_QUERY) ? '0 : idx_last;
			if (kind == KIND_INSERT && sts.full) begin
				stat_q <= STAT_FULL;
			end else if (kind == KIND_QUERY && sts.empty) begin
				stat_q <= STAT_EMPTY;
			end else begin
				stat_q <= STAT_OK;
			end
		end
		if (cmd.ins_step && !ins_stop) begin
			idx_q <= idx_q - IDX_W'(1);
		end
		if (cmd.qry_step) begin
			// strict less: walk is descending, so ties keep the larger value
			if (idx_q == '0 || diff < best_d_q) begin
				best_q   <= rdata;
				best_d_q <= diff;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.finish) begin
			nearest_q  <= hit ? best_q : '0;
			exact_q    <= hit && (best_d_q == '0);
			res_stat_q <= stat_q;
		end
	end

	assign nearest_value = nearest_q;
	assign exact_match   = exact_q;
	assign status        = res_stat_q;

endmodule

@@ rtl/core/stns_ctrl.sv @@
`include "sorted_table_nearest_search_macros.svh"

module stns_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic           kind,
	output logic           res_valid,
	input  logic           res_ready,
	output stns_pkg::cmd_t cmd,
	input  stns_pkg::sts_t sts
);
	import stns_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (kind == KIND_INSERT) begin
						if (sts.full) begin
							state_d = ST_FINISH;
						end else if (sts.empty) begin
							state_d = ST_INS_PUT;
						end else begin
							state_d = ST_INS_WALK;
						end
					end else begin
						state_d = sts.empty ? ST_FINISH : ST_QRY_WALK;
					end
				end
			end
			ST_INS_WALK: begin
				cmd.ins_step = 1'b1;
				if (sts.ins_stop) begin
					state_d = ST_FINISH;
				end else if (sts.idx_zero) begin
					state_d = ST_INS_PUT;
				end
			end
			ST_INS_PUT: begin
				cmd.ins_put = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_QRY_WALK: begin
				cmd.qry_step = 1'b1;
				if (sts.qry_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`STNS_ASSERT_NOW(a_finish_slot, cmd.finish, !out_valid_q || res_ready, "result overwritten")
	`STNS_ASSERT_NOW(a_qry_nonempty, state_q == ST_QRY_WALK, !sts.empty, "query walk on empty table")
	`STNS_ASSERT_NOW(a_ins_notfull, state_q == ST_INS_WALK, !sts.full, "insert walk on full table")
	`STNS_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "request accepted but idle")

endmodule
